[design/frustum_plane_cull_test_defines.svh]
// Assertion macros shared by the frustum plane cull test design.
// No dependencies; included by the files that carry assertions.
`ifndef FRUSTUM_PLANE_CULL_TEST_DEFINES_SVH
`define FRUSTUM_PLANE_CULL_TEST_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fpc_pkg.sv]
// Shared types and constants for the frustum plane cull test.
// No dependencies.
package fpc_pkg;

    localparam int FPC_NUM_PLANES = 6;
    localparam int FPC_Q_DEPTH    = 4;
    localparam int FPC_W          = 32;   // Q16.16 word
    localparam int FPC_PROD_W     = 64;   // Q32.32 product
    localparam int FPC_SUM_W      = 50;   // three rescaled products plus d
    localparam int FPC_SHIFT      = 16;
    localparam int FPC_IDX_W      = 3;
    localparam int FPC_OP_W       = 2;

    localparam logic signed [FPC_W-1:0] FPC_EPS_RST = 32'sd327680;   // 5.0

    typedef enum logic [FPC_OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_POINT  = 2'd1,
        OP_SPHERE = 2'd2
    } t_op;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TEST = 1'b1
    } t_kind;

    // Load: a, b, c, d.  Test: x, y, z, margin.
    typedef struct packed {
        logic signed [FPC_W-1:0] w0;
        logic signed [FPC_W-1:0] w1;
        logic signed [FPC_W-1:0] w2;
        logic signed [FPC_W-1:0] w3;
    } t_quad;

    typedef struct packed {
        t_kind                kind;
        logic [FPC_IDX_W-1:0] idx;
        t_quad                data;
    } t_q_item;

    typedef struct packed {
        logic empty;
        logic full;
        logic almost_full;
    } t_q_stat;

endpackage

[design/fpc_front.sv]
// Front end: accepts items, resolves the test margin, drops no-op items.
// Depends on fpc_pkg.
module fpc_front #(
    parameter int NUM_PLANES = fpc_pkg::FPC_NUM_PLANES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [fpc_pkg::FPC_OP_W-1:0]        i_op,
    input  logic [fpc_pkg::FPC_IDX_W-1:0]       i_plane_index,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_coef_a,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_coef_b,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_coef_c,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_coef_d,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_pos_x,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_pos_y,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_pos_z,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_radius,
    input  logic                                i_cfg_we,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_cfg_wdata,
    output logic                                o_push,
    output fpc_pkg::t_q_item                    o_item
);

    logic signed [fpc_pkg::FPC_W-1:0] r_eps;
    logic                             r_vld;
    logic                             n_vld;
    fpc_pkg::t_q_item                 r_item;
    fpc_pkg::t_q_item                 n_item;
    logic                             idx_ok;

    assign idx_ok = 32'(i_plane_index) < 32'(NUM_PLANES);

    always_comb begin
        n_vld       = 1'b0;
        n_item.kind = fpc_pkg::KIND_TEST;
        n_item.idx  = i_plane_index;
        n_item.data = '{i_pos_x, i_pos_y, i_pos_z, r_eps};
        unique case (fpc_pkg::t_op'(i_op))
            fpc_pkg::OP_LOAD: begin
                n_vld       = i_accept && idx_ok;    // out-of-range loads vanish
                n_item.kind = fpc_pkg::KIND_LOAD;
                n_item.data = '{i_coef_a, i_coef_b, i_coef_c, i_coef_d};
            end
            fpc_pkg::OP_POINT: begin
                n_vld = i_accept;
            end
            fpc_pkg::OP_SPHERE: begin
                n_vld          = i_accept;
                n_item.data.w3 = i_radius;
            end
            default: begin
                n_vld = 1'b0;                         // unused opcode
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= fpc_pkg::FPC_EPS_RST;
            r_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_wdata;
            end
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_vld) begin
            r_item <= n_item;
        end
    end

    assign o_push = r_vld;
    assign o_item = r_item;

endmodule

[design/fpc_fifo.sv]
// Short queue between the front end and the plane evaluator.
// Depends on fpc_pkg and frustum_plane_cull_test_defines.svh.
`include "frustum_plane_cull_test_defines.svh"
module fpc_fifo #(
    parameter int DEPTH = fpc_pkg::FPC_Q_DEPTH    // 2 or more
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fpc_pkg::t_q_item   i_push_item,
    input  logic               i_pop,
    output fpc_pkg::t_q_item   o_head,
    output fpc_pkg::t_q_stat   o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    fpc_pkg::t_q_item r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_inc(r_rd);
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    assign o_head             = r_mem[r_rd];
    assign o_stat.empty       = (r_count == '0);
    assign o_stat.full        = (r_count == CW'(DEPTH));
    assign o_stat.almost_full = (r_count >= CW'(DEPTH - 1));

    `FPC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_stat.full || i_pop, "queue overflow")
    `FPC_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, !o_stat.empty, "queue underflow")
    `FPC_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CW'(1), "queue count lost a push")

endmodule

[design/fpc_back.sv]
// Back end: plane store and the three-stage distance/margin pipeline.
// Depends on fpc_pkg and frustum_plane_cull_test_defines.svh.
`include "frustum_plane_cull_test_defines.svh"
module fpc_back #(
    parameter int NUM_PLANES = fpc_pkg::FPC_NUM_PLANES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  fpc_pkg::t_q_item   i_item,
    output logic               o_done,
    output logic               o_inside_res
);

    localparam int W  = fpc_pkg::FPC_W;
    localparam int PW = fpc_pkg::FPC_PROD_W;
    localparam int SW = fpc_pkg::FPC_SUM_W;
    localparam logic signed [SW-1:0] SUM_MAX = SW'(32'sh7FFF_FFFF);
    localparam logic signed [SW-1:0] SUM_MIN = SW'(-33'sh0_8000_0000);

    fpc_pkg::t_quad         r_plane [NUM_PLANES];
    logic signed [PW-1:0]   r_prod_a [NUM_PLANES];
    logic signed [PW-1:0]   r_prod_b [NUM_PLANES];
    logic signed [PW-1:0]   r_prod_c [NUM_PLANES];
    logic signed [W-1:0]    r_d1 [NUM_PLANES];
    logic signed [SW-1:0]   r_sum [NUM_PLANES];
    logic signed [W-1:0]    r_m1;
    logic signed [W-1:0]    r_m2;
    logic                   r_v1;
    logic                   r_v2;
    logic                   r_done;
    logic                   r_inside;
    logic [NUM_PLANES-1:0]  pass;
    logic                   pop_test;
    logic                   pop_load;

    assign pop_test = i_vld && (i_item.kind == fpc_pkg::KIND_TEST);
    assign pop_load = i_vld && (i_item.kind == fpc_pkg::KIND_LOAD);

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
        logic                 hit;
        logic signed [SW-1:0] sat_in;
        logic signed [W-1:0]  lane_dist;

        assign hit = pop_load && (32'(i_item.idx) == 32'(p));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_plane[p] <= '0;
            end else if (hit) begin
                r_plane[p] <= i_item.data;
            end
        end

        // stage 1: Q32.32 products
        always_ff @(posedge i_clk) begin
            if (pop_test) begin
                r_prod_a[p] <= PW'(r_plane[p].w0) * PW'(i_item.data.w0);
                r_prod_b[p] <= PW'(r_plane[p].w1) * PW'(i_item.data.w1);
                r_prod_c[p] <= PW'(r_plane[p].w2) * PW'(i_item.data.w2);
                r_d1[p]     <= r_plane[p].w3;
            end
        end

        // stage 2: floor rescale and exact sum
        always_ff @(posedge i_clk) begin
            if (r_v1) begin
                r_sum[p] <= SW'(r_prod_a[p] >>> fpc_pkg::FPC_SHIFT)
                          + SW'(r_prod_b[p] >>> fpc_pkg::FPC_SHIFT)
                          + SW'(r_prod_c[p] >>> fpc_pkg::FPC_SHIFT)
                          + SW'(r_d1[p]);
            end
        end

        // stage 3: saturate, strict compare against the margin
        assign sat_in = r_sum[p];
        always_comb begin
            priority if (sat_in > SUM_MAX) begin
                lane_dist = SUM_MAX[W-1:0];
            end else if (sat_in < SUM_MIN) begin
                lane_dist = SUM_MIN[W-1:0];
            end else begin
                lane_dist = sat_in[W-1:0];
            end
        end
        assign pass[p] = !(lane_dist > r_m2);
    end

    always_ff @(posedge i_clk) begin
        if (pop_test) begin
            r_m1 <= i_item.data.w3;
        end
        if (r_v1) begin
            r_m2 <= r_m1;
        end
        r_inside <= &pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= pop_test;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    assign o_done       = r_done;
    assign o_inside_res = r_inside;

    `FPC_ASSERT_IMP(a_done_from_test, i_clk, i_rst_n, r_done, $past(pop_test, 3), "result without a test item")

endmodule

[design/frustum_plane_cull_test.sv]
// Top level of the frustum plane cull test: front end, queue, evaluator.
// Depends on fpc_pkg, fpc_front, fpc_fifo and fpc_back.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  item in   | start & !busy      | i_op, i_plane_index, i_coef_a..d, i_pos_x..z,
//            |                    | i_radius
//  config    | i_cfg_we           | i_cfg_wdata (point epsilon, Q16.16)
//  result    | o_done (1 cycle)   | o_inside_res
//
// One item per cycle while busy is low. A test result passes through the
// front register (written at the accepting edge), the queue write, the
// product stage (three multipliers per plane, all planes in parallel), the
// sum stage and the compare stage.
// Loads write the plane store as they leave the queue, so tests see planes
// in item order. Loads, out-of-range loads and unused opcodes give no result.
// Reset is synchronous: planes clear to zero, epsilon returns to 5.0.
// The evaluator pops whenever the queue is not empty, so busy rises only if
// the queue nears full; results cannot be held off by the receiver.
module frustum_plane_cull_test #(
    parameter int NUM_PLANES  = fpc_pkg::FPC_NUM_PLANES,   // 1..8
    parameter int QUEUE_DEPTH = fpc_pkg::FPC_Q_DEPTH       // 2 or more
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [fpc_pkg::FPC_OP_W-1:0]        i_op,
    input  logic [fpc_pkg::FPC_IDX_W-1:0]       i_plane_index,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_coef_a,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_coef_b,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_coef_c,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_coef_d,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_pos_x,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_pos_y,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_pos_z,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_radius,
    input  logic                                i_cfg_we,
    input  logic signed [fpc_pkg::FPC_W-1:0]    i_cfg_wdata,
    output logic                                o_done,
    output logic                                o_inside_res
);

    logic              accept;
    logic              push;
    logic              pop;
    fpc_pkg::t_q_item  push_item;
    fpc_pkg::t_q_item  head;
    fpc_pkg::t_q_stat  q_stat;

    // Room is kept for the item sitting in the front register.
    assign busy   = q_stat.almost_full;
    assign accept = start && !busy;
    assign pop    = !q_stat.empty;

    fpc_front #(
        .NUM_PLANES (NUM_PLANES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_op          (i_op),
        .i_plane_index (i_plane_index),
        .i_coef_a      (i_coef_a),
        .i_coef_b      (i_coef_b),
        .i_coef_c      (i_coef_c),
        .i_coef_d      (i_coef_d),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_radius      (i_radius),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_push        (push),
        .o_item        (push_item)
    );

    fpc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    fpc_back #(
        .NUM_PLANES (NUM_PLANES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (pop),
        .i_item       (head),
        .o_done       (o_done),
        .o_inside_res (o_inside_res)
    );

endmodule

[tb/frustum_plane_cull_test_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the frustum plane cull test: mirrors plane loads and epsilon
// writes, predicts the inside flag of every test item and checks each result.
// Depends on fpc_pkg.
module frustum_plane_cull_test_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic [fpc_pkg::FPC_OP_W-1:0]     i_op,
    input  logic [fpc_pkg::FPC_IDX_W-1:0]    i_plane_index,
    input  logic signed [fpc_pkg::FPC_W-1:0] i_coef_a,
    input  logic signed [fpc_pkg::FPC_W-1:0] i_coef_b,
    input  logic signed [fpc_pkg::FPC_W-1:0] i_coef_c,
    input  logic signed [fpc_pkg::FPC_W-1:0] i_coef_d,
    input  logic signed [fpc_pkg::FPC_W-1:0] i_pos_x,
    input  logic signed [fpc_pkg::FPC_W-1:0] i_pos_y,
    input  logic signed [fpc_pkg::FPC_W-1:0] i_pos_z,
    input  logic signed [fpc_pkg::FPC_W-1:0] i_radius,
    input  logic                             i_cfg_we,
    input  logic signed [fpc_pkg::FPC_W-1:0] i_cfg_wdata,
    input  logic                             i_done,
    input  logic                             i_inside_res,
    output int                               o_mismatch_count,
    output int                               o_pending
);
    import fpc_pkg::*;

    typedef struct packed {
        logic signed [FPC_W-1:0] a;
        logic signed [FPC_W-1:0] b;
        logic signed [FPC_W-1:0] c;
        logic signed [FPC_W-1:0] d;
    } plane_coef_t;

    localparam logic signed [FPC_W-1:0] DIST_HI = 32'sh7FFF_FFFF;
    localparam logic signed [FPC_W-1:0] DIST_LO = 32'sh8000_0000;

    plane_coef_t plane_store [FPC_NUM_PLANES];
    logic signed [FPC_W-1:0] epsilon_q = FPC_EPS_RST;
    logic pending_inside [$];
    int   mismatch_count = 0;

    initial begin
        o_mismatch_count = 0;
        o_pending        = 0;
    end

    // Q32.32 products floored back to Q16.16, summed exactly, clamped to 32 bits.
    function automatic logic signed [FPC_W-1:0] plane_distance(
        input plane_coef_t p,
        input logic signed [FPC_W-1:0] x,
        input logic signed [FPC_W-1:0] y,
        input logic signed [FPC_W-1:0] z
    );
        longint acc;
        acc = ((longint'($signed(p.a)) * longint'(x)) >>> FPC_SHIFT)
            + ((longint'($signed(p.b)) * longint'(y)) >>> FPC_SHIFT)
            + ((longint'($signed(p.c)) * longint'(z)) >>> FPC_SHIFT)
            + longint'($signed(p.d));
        if (acc > longint'(DIST_HI))
            return DIST_HI;
        if (acc < longint'(DIST_LO))
            return DIST_LO;
        return acc[FPC_W-1:0];
    endfunction

    // Strict compare: a distance equal to the margin still counts as inside.
    function automatic logic within_frustum(
        input logic signed [FPC_W-1:0] x,
        input logic signed [FPC_W-1:0] y,
        input logic signed [FPC_W-1:0] z,
        input logic signed [FPC_W-1:0] margin
    );
        for (int i = 0; i < FPC_NUM_PLANES; i++) begin
            if (plane_distance(plane_store[i], x, y, z) > margin)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            foreach (plane_store[i])
                plane_store[i] = '0;
            epsilon_q = FPC_EPS_RST;
            pending_inside.delete();
        end else begin
            // results first: a result never belongs to an item taken at this edge
            if (i_done) begin
                if (pending_inside.size() == 0) begin
                    $error("result with no test outstanding: inside_res=%0b", i_inside_res);
                    mismatch_count++;
                end else begin
                    want = pending_inside.pop_front();
                    if (i_inside_res !== want) begin
                        $error("inside_res mismatch: expected %0b, actual %0b",
                               want, i_inside_res);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we)
                epsilon_q = i_cfg_wdata;
            if (i_start && !i_busy) begin
                case (i_op)
                    OP_LOAD: begin
                        if (i_plane_index < FPC_NUM_PLANES)
                            plane_store[i_plane_index] = '{a: i_coef_a, b: i_coef_b,
                                                           c: i_coef_c, d: i_coef_d};
                    end
                    OP_POINT:
                        pending_inside.push_back(
                            within_frustum(i_pos_x, i_pos_y, i_pos_z, epsilon_q));
                    OP_SPHERE:
                        pending_inside.push_back(
                            within_frustum(i_pos_x, i_pos_y, i_pos_z, i_radius));
                    default: ;
                endcase
            end
        end
        o_pending        <= pending_inside.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

[tb/frustum_plane_cull_test_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the frustum plane cull test: clock, reset, item stimulus
// and the verdict. Depends on fpc_pkg, frustum_plane_cull_test and
// frustum_plane_cull_test_checker.
module frustum_plane_cull_test_tb;
    import fpc_pkg::*;

    // op code the block must ignore
    localparam logic [FPC_OP_W-1:0] OP_RESERVED = 2'd3;

    localparam logic signed [FPC_W-1:0] Q_ONE = 32'sh0001_0000;   // 1.0
    localparam logic signed [FPC_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FPC_W-1:0] Q_MIN = 32'sh8000_0000;

    localparam int SETTLE_CYCLES = 10;     // pipeline is 5 registers deep, the queue included
    localparam int DRAIN_LIMIT   = 1000;   // cycles to wait for stragglers

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    start         = 1'b0;
    logic [FPC_OP_W-1:0]     i_op          = '0;
    logic [FPC_IDX_W-1:0]    i_plane_index = '0;
    logic signed [FPC_W-1:0] i_coef_a      = '0;
    logic signed [FPC_W-1:0] i_coef_b      = '0;
    logic signed [FPC_W-1:0] i_coef_c      = '0;
    logic signed [FPC_W-1:0] i_coef_d      = '0;
    logic signed [FPC_W-1:0] i_pos_x       = '0;
    logic signed [FPC_W-1:0] i_pos_y       = '0;
    logic signed [FPC_W-1:0] i_pos_z       = '0;
    logic signed [FPC_W-1:0] i_radius      = '0;
    logic                    i_cfg_we      = 1'b0;
    logic signed [FPC_W-1:0] i_cfg_wdata   = '0;
    logic                    busy;
    logic                    o_done;
    logic                    o_inside_res;

    int mismatch_count;
    int pending_results;

    // stimulus bookkeeping
    int sender_idle_pct = 0;
    int useful_items    = 0;   // loads to a real plane and tests
    int test_items      = 0;
    int load_items      = 0;
    int ignored_items   = 0;
    int eps_writes      = 0;
    bit drain_failed    = 1'b0;

    always #4 i_clk = ~i_clk;

    frustum_plane_cull_test dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_plane_index (i_plane_index),
        .i_coef_a      (i_coef_a),
        .i_coef_b      (i_coef_b),
        .i_coef_c      (i_coef_c),
        .i_coef_d      (i_coef_d),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_radius      (i_radius),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_inside_res  (o_inside_res)
    );

    frustum_plane_cull_test_checker u_cull_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_op             (i_op),
        .i_plane_index    (i_plane_index),
        .i_coef_a         (i_coef_a),
        .i_coef_b         (i_coef_b),
        .i_coef_c         (i_coef_c),
        .i_coef_d         (i_coef_d),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_radius         (i_radius),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_done           (o_done),
        .i_inside_res     (o_inside_res),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_results)
    );

    // Mostly moderate Q16.16 magnitudes so sums stay in range; some full-range
    // words to hit every bit, some corner values to hit saturation.
    function automatic logic signed [FPC_W-1:0] rand_word();
        int mag;
        case ($urandom_range(9))
            0: return $urandom;
            1: begin
                case ($urandom_range(4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 0;
                    3: return 1;
                    default: return -1;
                endcase
            end
            default: begin
                mag = $urandom_range(0, 1 << $urandom_range(4, 24));
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    // One item: optional idle cycles, then hold start until the block takes it.
    // Called at a rising edge; returns at the edge that accepted the item.
    task automatic send_item(
        input logic [FPC_OP_W-1:0]  op,
        input logic [FPC_IDX_W-1:0] idx,
        input logic signed [FPC_W-1:0] a, b, c, d,
        input logic signed [FPC_W-1:0] x, y, z, r
    );
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_plane_index <= idx;
        i_coef_a      <= a;
        i_coef_b      <= b;
        i_coef_c      <= c;
        i_coef_d      <= d;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_pos_z       <= z;
        i_radius      <= r;
        do @(posedge i_clk); while (busy);
        if (op == OP_POINT || op == OP_SPHERE) begin
            test_items++;
            useful_items++;
        end else if (op == OP_LOAD && idx < FPC_NUM_PLANES) begin
            load_items++;
            useful_items++;
        end else begin
            ignored_items++;
        end
    endtask

    // Stop sending, let every outstanding result come back, then give
    // trailing loads time to leave the pipe.
    task automatic wait_quiet();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results != 0) begin
            $error("%0d expected results never arrived", pending_results);
            drain_failed = 1'b1;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_epsilon(input logic signed [FPC_W-1:0] value);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        eps_writes++;
    endtask

    // Axis-aligned box as six planes: even planes face +axis, odd face -axis.
    // Distance to plane = sgn*(p - center) - half, so points within half of
    // the center on every axis are inside. Jitter tilts normals slightly and
    // now and then leaves a plane from the previous box in place.
    task automatic load_box(input int cx, cy, cz, half, input bit jitter);
        int ctr [3];
        int nrm [3];
        int axis;
        int sgn;
        int p;
        int k;
        ctr = '{cx, cy, cz};
        for (p = 0; p < FPC_NUM_PLANES; p++) begin
            if (jitter && $urandom_range(7) == 0)
                continue;
            axis = p / 2;
            sgn  = (p % 2) ? -1 : 1;
            for (k = 0; k < 3; k++) begin
                nrm[k] = (k == axis) ? sgn * Q_ONE : 0;
                if (jitter && $urandom_range(1))
                    nrm[k] += $urandom_range(0, 1024) - 512;
            end
            send_item(OP_LOAD, FPC_IDX_W'(p), nrm[0], nrm[1], nrm[2],
                      -(sgn * ctr[axis]) - half,
                      rand_word(), rand_word(), rand_word(), rand_word());
        end
    endtask

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int phase_items [5];
        int phase_idle  [5];
        logic signed [FPC_W-1:0] eps;
        logic signed [FPC_W-1:0] r;
        logic [FPC_OP_W-1:0]     op;
        int ctr [3];
        int pt  [3];
        int half;
        int goal;
        int ph;
        int k;

        phase_items = '{600, 100, 100, 550, 600};
        phase_idle  = '{38, 38, 48, 48, 0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, epsilon at its reset value of 5.0 ----
        sender_idle_pct = 20;
        // cleared planes give distance 0 everywhere
        send_item(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, -1);            // 0 > -1: outside
        send_item(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0);             // equal: inside
        // a test ignores plane index, coefficients, and radius in point mode
        send_item(OP_POINT, 7, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, Q_MIN);
        // saturation high
        send_item(OP_LOAD, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0);
        send_item(OP_POINT, 0, 0, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, 0);
        // saturation low lands exactly on a minimum radius: plane 0 still passes
        send_item(OP_LOAD, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0);
        send_item(OP_SPHERE, 0, 0, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
        // most negative times most negative: the largest product
        send_item(OP_POINT, 0, 0, 0, 0, 0, Q_MIN, Q_MIN, Q_MIN, 0);
        // tiny plane for the rounding check
        send_item(OP_LOAD, 0, 1, 0, 0, 0, 0, 0, 0, 0);
        // loads past the last plane and the unused op must change nothing
        send_item(OP_LOAD, 6, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_item(OP_LOAD, 7, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_item(OP_RESERVED, 7, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        // rescale floors: 1 * -1 in Q32.32 becomes -1, not 0
        send_item(OP_SPHERE, 0, 0, 0, 0, 0, -1, 0, 0, -1);
        send_item(OP_SPHERE, 0, 0, 0, 0, 0, -1, 0, 0, -2);
        send_item(OP_POINT, 0, 0, 0, 0, 0, Q_MAX, 0, 0, 0);
        // unit box of half size 2.0: x = 7.0 sits exactly on the 5.0 margin
        load_box(0, 0, 0, 2 * Q_ONE, 1'b0);
        send_item(OP_POINT, 0, 0, 0, 0, 0, 7 * Q_ONE, 0, 0, 0);
        send_item(OP_POINT, 0, 0, 0, 0, 0, 7 * Q_ONE + 1, 0, 0, 0);

        // ---- random part: five epsilon settings, idle rate set per phase ----
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       eps = 0;
                1:       eps = Q_MAX;
                2:       eps = Q_MIN;
                3:       eps = $urandom_range(0, 1 << 22);
                default: eps = 0 - int'($urandom_range(0, 1 << 20));
            endcase
            // each write drains the pipe first, so the sender pauses here
            write_epsilon(eps);
            sender_idle_pct = phase_idle[ph];
            goal = useful_items + phase_items[ph];
            while (useful_items < goal) begin
                if ($urandom_range(4) == 0) begin
                    // noise: any op, any index, any field
                    repeat ($urandom_range(1, 6))
                        send_item(FPC_OP_W'($urandom_range(3)),
                                  FPC_IDX_W'($urandom_range(7)),
                                  rand_word(), rand_word(), rand_word(), rand_word(),
                                  rand_word(), rand_word(), rand_word(), rand_word());
                end else begin
                    // scene: a fresh box, then tests scattered around it
                    for (k = 0; k < 3; k++)
                        ctr[k] = $urandom_range(0, 1 << 25) - (1 << 24);
                    half = $urandom_range(1 << 12, 1 << 22);
                    load_box(ctr[0], ctr[1], ctr[2], half, 1'b1);
                    repeat ($urandom_range(3, 12)) begin
                        for (k = 0; k < 3; k++) begin
                            if ($urandom_range(15) == 0)
                                pt[k] = rand_word();
                            else
                                pt[k] = ctr[k] + ($urandom_range(0, 4 * half) - 2 * half);
                        end
                        op = $urandom_range(1) ? OP_POINT : OP_SPHERE;
                        if ($urandom_range(7) == 0)
                            r = rand_word();
                        else
                            r = $urandom_range(0, 2 * half) - half;
                        send_item(op, FPC_IDX_W'($urandom_range(7)),
                                  rand_word(), rand_word(), rand_word(), rand_word(),
                                  pt[0], pt[1], pt[2], r);
                    end
                end
            end
        end

        wait_quiet();

        $display("covered %0d tests, %0d plane loads, %0d ignored items, %0d epsilon settings",
                 test_items, load_items, ignored_items, eps_writes);
        if (mismatch_count == 0 && !drain_failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
